// File: hdl/rcm_pkg.sv
// Shared types, rotor wirings and mod-26 helpers for the rotor cipher machine.
package rcm_pkg;

    typedef logic [4:0] let_t;
    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_START_LEFT   = 3'd0;
    localparam reg_idx_t REG_START_MIDDLE = 3'd1;
    localparam reg_idx_t REG_START_RIGHT  = 3'd2;
    localparam reg_idx_t REG_RING_LEFT    = 3'd3;
    localparam reg_idx_t REG_RING_MIDDLE  = 3'd4;
    localparam reg_idx_t REG_RING_RIGHT   = 3'd5;

    localparam let_t NUM_LETTERS  = 5'd26;
    localparam let_t LAST_LETTER  = 5'd25;
    localparam let_t NOTCH_MIDDLE = 5'd4;
    localparam let_t NOTCH_RIGHT  = 5'd21;

    localparam logic [7:0] ASCII_A = 8'd65;
    localparam logic [7:0] ASCII_Z = 8'd90;

    localparam int NUM_STAGES = 7;

    typedef logic [8*26-1:0] wiring_t;

    localparam wiring_t WIRE_I_FWD   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    localparam wiring_t WIRE_II_FWD  = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
    localparam wiring_t WIRE_III_FWD = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    localparam wiring_t WIRE_I_INV   = "UWYGADFPVZBECKMTHXSLRINQOJ";
    localparam wiring_t WIRE_II_INV  = "AJPCZWRLFBDKOTYUQGENHXMIVS";
    localparam wiring_t WIRE_III_INV = "TAGBPCSDQEUFVNZHYIXJWLRKOM";
    localparam wiring_t WIRE_REFL_B  = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    // Letter and rotor shifts for one enciphering transaction.
    typedef struct packed {
        let_t c;
        let_t sh_left;
        let_t sh_middle;
        let_t sh_right;
    } ciph_t;

    function automatic let_t mod26(input let_t v);
        return (v >= NUM_LETTERS) ? let_t'(v - NUM_LETTERS) : v;
    endfunction

    function automatic let_t inc26(input let_t v);
        return (v == LAST_LETTER) ? 5'd0 : let_t'(v + 5'd1);
    endfunction

    function automatic let_t add26(input let_t a, input let_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, NUM_LETTERS}) ? let_t'(s - {1'b0, NUM_LETTERS}) : s[4:0];
    endfunction

    function automatic let_t sub26(input let_t a, input let_t b);
        return (a >= b) ? let_t'(a - b) : let_t'(a + NUM_LETTERS - b);
    endfunction

    function automatic let_t wire_sub(input wiring_t w, input let_t x);
        logic [7:0] b;
        b = 8'd0;
        if (x < NUM_LETTERS)
        begin
            b = w[8*(25 - int'(x)) +: 8];
        end
        return let_t'(b - ASCII_A);
    endfunction

    function automatic let_t rotor_pass(input wiring_t w, input let_t c, input let_t sh);
        return sub26(wire_sub(w, add26(c, sh)), sh);
    endfunction

endpackage

// File: hdl/rcm_front.sv
// Front end: configuration registers, rotor positions, input classification and stepping.
module rcm_front
    import rcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  reg_idx_t   cfg_index,
    input  let_t       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] char_in,
    input  logic       q_full,
    output logic       q_push,
    output ciph_t      q_wdata
);

    let_t start_l_reg, start_m_reg, start_r_reg;
    let_t ring_l_reg, ring_m_reg, ring_r_reg;
    let_t pos_l_reg, pos_m_reg, pos_r_reg;
    let_t pos_l_next, pos_m_next, pos_r_next;
    logic accept;
    logic is_letter;
    logic mid_notch;
    logic right_notch;
    let_t step_l, step_m, step_r;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign is_letter = (char_in >= ASCII_A) && (char_in <= ASCII_Z);

    assign mid_notch   = (pos_m_reg == NOTCH_MIDDLE);
    assign right_notch = (pos_r_reg == NOTCH_RIGHT);
    assign step_l = mid_notch ? inc26(pos_l_reg) : pos_l_reg;
    assign step_m = (mid_notch || right_notch) ? inc26(pos_m_reg) : pos_m_reg;
    assign step_r = inc26(pos_r_reg);

    always_comb
    begin
        pos_l_next = pos_l_reg;
        pos_m_next = pos_m_reg;
        pos_r_next = pos_r_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            if (kind)
            begin
                pos_l_next = start_l_reg;
                pos_m_next = start_m_reg;
                pos_r_next = start_r_reg;
            end
            else if (is_letter)
            begin
                pos_l_next = step_l;
                pos_m_next = step_m;
                pos_r_next = step_r;
                q_push     = 1'b1;
            end
        end
    end

    assign q_wdata.c         = let_t'(char_in - ASCII_A);
    assign q_wdata.sh_left   = sub26(step_l, ring_l_reg);
    assign q_wdata.sh_middle = sub26(step_m, ring_m_reg);
    assign q_wdata.sh_right  = sub26(step_r, ring_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_l_reg <= '0;
            start_m_reg <= '0;
            start_r_reg <= '0;
            ring_l_reg  <= '0;
            ring_m_reg  <= '0;
            ring_r_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_LEFT:   start_l_reg <= mod26(cfg_data);
                REG_START_MIDDLE: start_m_reg <= mod26(cfg_data);
                REG_START_RIGHT:  start_r_reg <= mod26(cfg_data);
                REG_RING_LEFT:    ring_l_reg  <= mod26(cfg_data);
                REG_RING_MIDDLE:  ring_m_reg  <= mod26(cfg_data);
                REG_RING_RIGHT:   ring_r_reg  <= mod26(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_l_reg <= '0;
            pos_m_reg <= '0;
            pos_r_reg <= '0;
        end
        else
        begin
            pos_l_reg <= pos_l_next;
            pos_m_reg <= pos_m_next;
            pos_r_reg <= pos_r_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_l_reg < NUM_LETTERS && pos_m_reg < NUM_LETTERS && pos_r_reg < NUM_LETTERS)
        else $error("rotor position out of range");

    a_right_steps: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> pos_r_reg == inc26($past(pos_r_reg)))
        else $error("right rotor failed to step");

endmodule

// File: hdl/rcm_queue.sv
// Short queue between the front end and the cipher pipeline.
module rcm_queue
    import rcm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  ciph_t wdata,
    output logic  full,
    output logic  rvalid,
    input  logic  pop,
    output ciph_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ciph_t            ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_FULL);
    assign rvalid = (count_reg != '0);
    assign rdata  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

// File: hdl/rcm_back.sv
// Cipher pipeline: three rotor passes, reflector, three inverse passes.
module rcm_back
    import rcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  ciph_t      q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_out
);

    ciph_t                 stage_reg [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    ciph_t                 src       [NUM_STAGES];
    ciph_t                 nxt       [NUM_STAGES];
    logic [NUM_STAGES-1:0] src_vld;
    logic [NUM_STAGES-1:0] adv;

    function automatic let_t stage_fn(input int k, input ciph_t e);
        let_t r;
        unique case (k)
            0:       r = rotor_pass(WIRE_III_FWD, e.c, e.sh_right);
            1:       r = rotor_pass(WIRE_II_FWD,  e.c, e.sh_middle);
            2:       r = rotor_pass(WIRE_I_FWD,   e.c, e.sh_left);
            3:       r = wire_sub(WIRE_REFL_B, e.c);
            4:       r = rotor_pass(WIRE_I_INV,   e.c, e.sh_left);
            5:       r = rotor_pass(WIRE_II_INV,  e.c, e.sh_middle);
            6:       r = rotor_pass(WIRE_III_INV, e.c, e.sh_right);
            default: r = e.c;
        endcase
        return r;
    endfunction

    always_comb
    begin
        src[0]     = q_data;
        src_vld[0] = q_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            src[k]     = stage_reg[k-1];
            src_vld[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            nxt[k]   = src[k];
            nxt[k].c = stage_fn(k, src[k]);
        end
    end

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign q_pop     = q_valid && adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign char_out  = 7'(stage_reg[NUM_STAGES-1].c) + 7'(ASCII_A);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (adv[k] && src_vld[k])
            begin
                stage_reg[k] <= nxt[k];
            end
        end
    end

    a_out_letter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_out >= 7'(ASCII_A) && char_out <= 7'(ASCII_Z)))
        else $error("result is not an uppercase letter");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && !adv[0]) |=> vld_reg[0] && $stable(stage_reg[0]))
        else $error("stalled stage lost its transaction");

endmodule

// File: hdl/rotor_cipher_machine.sv
// Top level of the three-rotor cipher machine (rotors I, II, III, reflector B).
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    kind, char_in
//  out       output     out_valid/out_ready  char_out
//  cfg       input      cfg_write            cfg_index, cfg_data
//
// One transaction per cycle while the queue is not full; an accepted letter is written into
// the queue, whose entry feeds the first of seven registered substitution stages.
// Rotor stepping and restarts complete in the front end in the accepting cycle.
// in_ready drops only while the queue is full; the pipeline stalls stage by
// stage from out_ready. Reset clears positions, registers, queue and pipeline.
module rotor_cipher_machine
    import rcm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_out
);

    logic  q_full;
    logic  q_push;
    ciph_t q_wdata;
    logic  q_valid;
    logic  q_pop;
    ciph_t q_rdata;

    rcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .char_in   (char_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    rcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .rvalid (q_valid),
        .pop    (q_pop),
        .rdata  (q_rdata)
    );

    rcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the three-rotor cipher machine with rotor stepping predictor.
module tb_top;
    import rcm_pkg::*;

    localparam logic KIND_CIPHER  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam reg_idx_t REG_SPARE_LO = 3'd6;
    localparam reg_idx_t REG_SPARE_HI = 3'd7;
    localparam int NUM_REGS = 6;
    localparam int LETTERS = 26;

    localparam int SETTLE_CYCLES    = 12;
    localparam int TAIL_CYCLES      = 20;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int RANDOM_ITEMS     = 1400;
    localparam int LONG_PHASE_ITEMS = 700;

    localparam string ROTOR_I     = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    localparam string ROTOR_II    = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
    localparam string ROTOR_III   = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    localparam string REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_SLOW, RX_LONG_STALL} rx_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [4:0] cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       kind      = 1'b0;
    logic [7:0] char_in   = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [6:0] char_out;

    logic [4:0] reg_shadow [NUM_REGS] = '{default: '0};
    int         rotor_left   = 0;
    int         rotor_middle = 0;
    int         rotor_right  = 0;
    logic [6:0] pending_letters [$];

    int       errors  = 0;
    int       cycles  = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    rotor_cipher_machine DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .char_in(char_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_out(char_out)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic int wire_fwd(input string w, input int x);
        return int'(w[x]) - int'(ASCII_A);
    endfunction

    function automatic int wire_back(input string w, input int y);
        int i;
        for (i = 0; i < LETTERS; i++)
        begin
            if (wire_fwd(w, i) == y)
            begin
                return i;
            end
        end
        return 0;
    endfunction

    function automatic int through_rotor(input string w, input int c, input int pos,
                                         input logic [4:0] ring, input bit back);
        int sh;
        int x;
        int y;
        sh = (pos + LETTERS - (int'(ring) % LETTERS)) % LETTERS;
        x  = (c + sh) % LETTERS;
        y  = back ? wire_back(w, x) : wire_fwd(w, x);
        return (y + LETTERS - sh) % LETTERS;
    endfunction

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= ASCII_A) && (ch <= ASCII_Z);
    endfunction

    // Step the rotors and queue the enciphered letter for one accepted transaction.
    function automatic void encipher_step(input logic k, input logic [7:0] ch);
        int c;
        bit middle_turn;
        bit right_turn;
        if (k == KIND_RESTART)
        begin
            rotor_left   = int'(reg_shadow[REG_START_LEFT]) % LETTERS;
            rotor_middle = int'(reg_shadow[REG_START_MIDDLE]) % LETTERS;
            rotor_right  = int'(reg_shadow[REG_START_RIGHT]) % LETTERS;
            return;
        end
        if (!is_letter(ch))
        begin
            return;
        end
        middle_turn = (rotor_middle == int'(NOTCH_MIDDLE));
        right_turn  = (rotor_right == int'(NOTCH_RIGHT));
        if (middle_turn)
        begin
            rotor_left   = (rotor_left + 1) % LETTERS;
            rotor_middle = (rotor_middle + 1) % LETTERS;
        end
        else if (right_turn)
        begin
            rotor_middle = (rotor_middle + 1) % LETTERS;
        end
        rotor_right = (rotor_right + 1) % LETTERS;

        c = int'(ch) - int'(ASCII_A);
        c = through_rotor(ROTOR_III, c, rotor_right, reg_shadow[REG_RING_RIGHT], 1'b0);
        c = through_rotor(ROTOR_II, c, rotor_middle, reg_shadow[REG_RING_MIDDLE], 1'b0);
        c = through_rotor(ROTOR_I, c, rotor_left, reg_shadow[REG_RING_LEFT], 1'b0);
        c = wire_fwd(REFLECTOR_B, c);
        c = through_rotor(ROTOR_I, c, rotor_left, reg_shadow[REG_RING_LEFT], 1'b1);
        c = through_rotor(ROTOR_II, c, rotor_middle, reg_shadow[REG_RING_MIDDLE], 1'b1);
        c = through_rotor(ROTOR_III, c, rotor_right, reg_shadow[REG_RING_RIGHT], 1'b1);
        pending_letters = {pending_letters, 7'(c + int'(ASCII_A))};
    endfunction

    // Receiver: switch among five randomly chosen stall patterns.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 4));
            rx_left <= $urandom_range(32, 256);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:       out_ready <= 1'b1;
            RX_COIN:       out_ready <= 1'($urandom_range(0, 1));
            RX_RARE_STALL: out_ready <= ($urandom_range(0, 7) != 0);
            RX_SLOW:       out_ready <= (cycles % 3 == 0);
            default:       out_ready <= ((cycles / 12) % 2 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_letters.size() == 0)
            begin
                $error("char_out expected none got %0d", char_out);
                errors = errors + 1;
            end
            else
            begin
                if (char_out !== pending_letters[0])
                begin
                    $error("char_out expected %0d got %0d", pending_letters[0], char_out);
                    errors = errors + 1;
                end
                void'(pending_letters.pop_front());
            end
        end
    end

    task automatic send_item(input logic k, input logic [7:0] ch);
        in_valid <= 1'b1;
        kind     <= k;
        char_in  <= ch;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        encipher_step(k, ch);
    endtask

    task automatic wait_drain;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_letters.size() != 0);
    endtask

    task automatic wait_idle;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold cfg_write high across back-to-back writes; cfg_done drops it.
    task automatic cfg_put(input reg_idx_t idx, input logic [4:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx < NUM_REGS)
        begin
            reg_shadow[idx] = value;
        end
    endtask

    task automatic cfg_done;
        cfg_write <= 1'b0;
    endtask

    function automatic logic [4:0] random_reg_value;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 5'd0;
        end
        if (pick == 1)
        begin
            return 5'd25;
        end
        if (pick == 2)
        begin
            return 5'($urandom_range(26, 31));
        end
        return 5'($urandom_range(0, 25));
    endfunction

    task automatic load_random_settings;
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                cfg_put(reg_idx_t'(i), random_reg_value());
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            cfg_put($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                    5'($urandom_range(0, 31)));
        end
        cfg_put(REG_RING_RIGHT, random_reg_value());
        cfg_done();
    endtask

    // Reset settings: all registers and rotors at A, plus every byte class.
    task automatic test_reset_state;
        send_item(KIND_CIPHER, "A");
        send_item(KIND_CIPHER, "Z");
        send_item(KIND_CIPHER, 8'h00);
        send_item(KIND_CIPHER, 8'hFF);
        send_item(KIND_CIPHER, "@");
        send_item(KIND_CIPHER, "[");
        send_item(KIND_CIPHER, "a");
        send_item(KIND_CIPHER, "z");
        send_item(KIND_RESTART, "Q");
        send_item(KIND_CIPHER, "A");
        send_item(KIND_CIPHER, "A");
        wait_idle();
    endtask

    // Start at A-D-U so the middle rotor double steps within four letters.
    task automatic test_double_step;
        cfg_put(REG_START_LEFT, 5'd0);
        cfg_put(REG_START_MIDDLE, 5'd3);
        cfg_put(REG_START_RIGHT, 5'd20);
        cfg_put(REG_RING_LEFT, 5'd0);
        cfg_put(REG_RING_MIDDLE, 5'd0);
        cfg_put(REG_RING_RIGHT, 5'd0);
        cfg_done();
        send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
        repeat (4) send_item(KIND_CIPHER, "A");
        wait_idle();
    endtask

    // Out-of-range values wrap modulo 26; writes to spare indexes drop.
    task automatic test_register_wrap;
        cfg_put(REG_START_LEFT, 5'd25);
        cfg_put(REG_START_MIDDLE, 5'd26);
        cfg_put(REG_START_RIGHT, 5'd31);
        cfg_put(REG_RING_LEFT, 5'd31);
        cfg_put(REG_RING_MIDDLE, 5'd26);
        cfg_put(REG_RING_RIGHT, 5'd25);
        cfg_put(REG_SPARE_LO, 5'd31);
        cfg_put(REG_SPARE_HI, 5'd0);
        cfg_done();
        send_item(KIND_RESTART, "A");
        send_item(KIND_CIPHER, "A");
        send_item(KIND_CIPHER, "B");
        send_item(KIND_CIPHER, "Z");
        send_item(KIND_CIPHER, "M");
        wait_idle();
    endtask

    task automatic run_phase(input int quota, input bit with_restarts, output int counted);
        int pause_at;
        int burst;
        int pick;
        bit paused;
        logic k;
        logic [7:0] ch;
        counted  = 0;
        paused   = 1'b0;
        pause_at = $urandom_range(1, quota - 1);
        while (counted < quota)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                k    = KIND_CIPHER;
                if (with_restarts && pick < 3)
                begin
                    k  = KIND_RESTART;
                    ch = 8'($urandom_range(0, 255));
                end
                else if (pick < 80)
                begin
                    ch = 8'($urandom_range(ASCII_A, ASCII_Z));
                end
                else
                begin
                    ch = 8'($urandom_range(0, 255));
                end
                send_item(k, ch);
                counted = counted + 1;
                if (!paused && counted >= pause_at)
                begin
                    paused = 1'b1;
                    wait_drain();
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // First phase runs long without restarts, so the middle rotor steps repeatedly.
    task automatic test_random_traffic;
        int sent;
        int phase;
        int counted;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            load_random_settings();
            send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
            run_phase(phase == 0 ? LONG_PHASE_ITEMS : $urandom_range(100, 200),
                      phase != 0, counted);
            sent  = sent + counted + 1;
            phase = phase + 1;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_double_step();
        test_register_wrap();
        test_random_traffic();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rcm_pkg.sv
hdl/rcm_front.sv
hdl/rcm_queue.sv
hdl/rcm_back.sv
hdl/rotor_cipher_machine.sv
tb/tb_top.sv
